// ===== hdl/yra_pkg.sv =====
package yra_pkg;

	localparam int unsigned MAX_DIM = 4096;
	localparam int unsigned DIM_W   = 13;
	localparam int unsigned POS_W   = 12;
	localparam int unsigned IDX_W   = 24;
	localparam int unsigned SAMP_W  = 8;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned ADDR_W  = 4;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned TERM_W  = 18;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
	localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

	typedef enum logic [1:0] {
		ROT_0   = 2'd0,
		ROT_90  = 2'd1,
		ROT_180 = 2'd2,
		ROT_270 = 2'd3
	} rot_t;

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH   = 2'd0,
		REG_IMAGE_HEIGHT  = 2'd1,
		REG_ROTATION_MODE = 2'd2,
		REG_FRONT_FACING  = 2'd3
	} reg_idx_t;

	// keep a written dimension within 1..MAX_DIM
	function automatic logic [DIM_W-1:0] sat_dim(input logic [DATA_W-1:0] v);
		logic [DIM_W-1:0] d;
		d = v[DIM_W-1:0];
		if (d == '0) begin
			return DIM_W'(1);
		end else if (d > DIM_W'(MAX_DIM)) begin
			return DIM_W'(MAX_DIM);
		end
		return d;
	endfunction

	// floor shift by 7 then clamp to 0..255
	function automatic logic [SAMP_W-1:0] to_channel(input logic signed [TERM_W-1:0] t);
		logic [9:0] q;
		q = t[16:7];
		if (t < 0) begin
			return '0;
		end else if (|q[9:8]) begin
			return '1;
		end
		return q[7:0];
	endfunction

endpackage

// ===== hdl/yra_pixel_if.sv =====
interface yra_pixel_if import yra_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SAMP_W-1:0] luma;
	logic [SAMP_W-1:0] chroma_blue;
	logic [SAMP_W-1:0] chroma_red;
	logic [POS_W-1:0]  src_row;
	logic [POS_W-1:0]  src_col;

	modport source(output valid, luma, chroma_blue, chroma_red, src_row, src_col,
		input ready);
	modport sink(input valid, luma, chroma_blue, chroma_red, src_row, src_col,
		output ready);
endinterface

// ===== hdl/yra_result_if.sv =====
interface yra_result_if import yra_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] pixel_word;
	logic [IDX_W-1:0]  dest_index;

	modport source(output valid, pixel_word, dest_index, input ready);
	modport sink(input valid, pixel_word, dest_index, output ready);
endinterface

// ===== hdl/yuv420_to_argb_rotate_fixed7.sv =====
// pipeline: an accepted pixel request passes the input register, then the result register
// throughput: 1 pixel per cycle while results are taken, set by one input register and one result register
// the 24x13 index multiply and the color terms sit between those two registers
// reset (arst_n low, asynchronous): pipeline empties, image 640x480, no rotation,
// no mirroring
module yuv420_to_argb_rotate_fixed7 import yra_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	yra_pixel_if.sink         pixel,
	yra_result_if.source      result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	// configuration registers
	logic [DIM_W-1:0] image_width_q;
	logic [DIM_W-1:0] image_height_q;
	rot_t             rotation_mode_q;
	logic             front_facing_q;

	reg_idx_t reg_sel;
	logic     cfg_wr;

	// stage 1: registered input request
	logic              valid_s1;
	logic [SAMP_W-1:0] luma_s1;
	logic [SAMP_W-1:0] chroma_blue_s1;
	logic [SAMP_W-1:0] chroma_red_s1;
	logic [POS_W-1:0]  src_row_s1;
	logic [POS_W-1:0]  src_col_s1;

	// stage 2: result register
	logic              valid_s2;
	logic [WORD_W-1:0] pixel_word_s2;
	logic [IDX_W-1:0]  dest_index_s2;

	logic adv_s2;
	logic take_in;

	// color datapath
	logic signed [8:0]        u_c;
	logic signed [8:0]        v_c;
	logic signed [TERM_W-1:0] y_x;
	logic signed [TERM_W-1:0] u_x;
	logic signed [TERM_W-1:0] v_x;
	logic signed [TERM_W-1:0] t_r;
	logic signed [TERM_W-1:0] t_g;
	logic signed [TERM_W-1:0] t_b;
	logic [WORD_W-1:0]        word_c;

	// index datapath, all arithmetic modulo 2^24
	logic [IDX_W-1:0]         w24;
	logic [IDX_W-1:0]         h24;
	logic [IDX_W-1:0]         r24;
	logic [IDX_W-1:0]         c24;
	logic [IDX_W-1:0]         cm;
	logic [IDX_W-1:0]         mul_a;
	logic [DIM_W-1:0]         mul_b;
	logic [IDX_W-1:0]         add_v;
	logic [IDX_W+DIM_W-1:0]   prod;
	logic [IDX_W-1:0]         index_c;

	// config port: zero wait states, writes land in the access phase
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= WIDTH_RESET;
			image_height_q  <= HEIGHT_RESET;
			rotation_mode_q <= ROT_0;
			front_facing_q  <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_IMAGE_WIDTH:   image_width_q   <= sat_dim(pwdata);
				REG_IMAGE_HEIGHT:  image_height_q  <= sat_dim(pwdata);
				REG_ROTATION_MODE: rotation_mode_q <= rot_t'(pwdata[1:0]);
				REG_FRONT_FACING:  front_facing_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_IMAGE_WIDTH:   prdata = DATA_W'(image_width_q);
			REG_IMAGE_HEIGHT:  prdata = DATA_W'(image_height_q);
			REG_ROTATION_MODE: prdata = DATA_W'(rotation_mode_q);
			REG_FRONT_FACING:  prdata = DATA_W'(front_facing_q);
			default:           prdata = '0;
		endcase
	end

	// handshake: result register moves when empty or taken, input stage
	// refills whenever it is empty or its content moves on
	assign adv_s2      = !valid_s2 || result.ready;
	assign pixel.ready = !valid_s1 || adv_s2;
	assign take_in     = pixel.valid && pixel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel.ready) begin
			valid_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			luma_s1        <= pixel.luma;
			chroma_blue_s1 <= pixel.chroma_blue;
			chroma_red_s1  <= pixel.chroma_red;
			src_row_s1     <= pixel.src_row;
			src_col_s1     <= pixel.src_col;
		end
	end

	// color matrix, 7 fractional bits; every term fits 18 bits signed
	always_comb begin
		u_c = $signed({1'b0, chroma_blue_s1}) - 9'sd128;
		v_c = $signed({1'b0, chroma_red_s1}) - 9'sd128;
		y_x = $signed({{(TERM_W-SAMP_W){1'b0}}, luma_s1});
		u_x = TERM_W'(u_c);
		v_x = TERM_W'(v_c);
		t_r = (y_x <<< 7) + 18'sd179 * v_x;
		t_g = (y_x <<< 7) - 18'sd44 * u_x - 18'sd91 * v_x;
		t_b = (y_x <<< 7) + 18'sd227 * u_x;
		word_c = {8'hFF, to_channel(t_b), to_channel(t_g), to_channel(t_r)};
	end

	// destination index: mirror first, then one multiply-add per rotation
	always_comb begin
		w24 = IDX_W'(image_width_q);
		h24 = IDX_W'(image_height_q);
		r24 = IDX_W'(src_row_s1);
		c24 = IDX_W'(src_col_s1);
		cm  = front_facing_q ? (w24 - IDX_W'(1) - c24) : c24;
		case (rotation_mode_q)
			ROT_0: begin
				mul_a = cm;
				mul_b = image_height_q;
				add_v = h24 - IDX_W'(1) - r24;
			end
			ROT_90: begin
				mul_a = r24;
				mul_b = image_width_q;
				add_v = cm;
			end
			ROT_180: begin
				mul_a = w24 - IDX_W'(1) - cm;
				mul_b = image_height_q;
				add_v = r24;
			end
			ROT_270: begin
				mul_a = h24 - IDX_W'(1) - r24;
				mul_b = image_width_q;
				add_v = w24 - IDX_W'(1) - cm;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
				add_v = '0;
			end
		endcase
		prod    = mul_a * mul_b;
		index_c = prod[IDX_W-1:0] + add_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			pixel_word_s2 <= word_c;
			dest_index_s2 <= index_c;
		end
	end

	assign result.valid      = valid_s2;
	assign result.pixel_word = pixel_word_s2;
	assign result.dest_index = dest_index_s2;

endmodule

// ===== tb/sv/yra_pixel_checker.sv =====
module yra_pixel_checker import yra_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	yra_pixel_if              pixel,
	yra_result_if             result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic [DATA_W-1:0] prdata,
	input  logic              pready,
	output int                mismatches,
	output int                pending
);

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [IDX_W-1:0]  index;
	} placed_pixel_t;

	logic [DIM_W-1:0]  cfg_width;
	logic [DIM_W-1:0]  cfg_height;
	rot_t              cfg_rot;
	logic              cfg_mirror;
	placed_pixel_t     pending_pixels[$];
	placed_pixel_t     want;
	logic [DATA_W-1:0] reg_value;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] exp_value);
		$display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, exp_value);
		mismatches++;
	endtask

	function automatic logic [DIM_W-1:0] saturate_dim(input logic [DIM_W-1:0] raw);
		if (raw == '0) begin
			return DIM_W'(1);
		end
		if (raw > DIM_W'(MAX_DIM)) begin
			return DIM_W'(MAX_DIM);
		end
		return raw;
	endfunction

	// floor shift by 7, then clamp to one byte
	function automatic logic [7:0] clamp_channel(input int t);
		int q;
		if (t < 0) begin
			return 8'd0;
		end
		q = t >>> 7;
		if (q > 255) begin
			return 8'hFF;
		end
		return 8'(q);
	endfunction

	function automatic placed_pixel_t convert_pixel(input logic [SAMP_W-1:0] y8,
		input logic [SAMP_W-1:0] u8, input logic [SAMP_W-1:0] v8,
		input logic [POS_W-1:0] row, input logic [POS_W-1:0] col);
		int            y;
		int            u;
		int            v;
		logic [31:0]   r;
		logic [31:0]   c;
		logic [31:0]   w;
		logic [31:0]   h;
		logic [31:0]   idx;
		placed_pixel_t p;
		y = int'(y8);
		u = int'(u8) - 128;
		v = int'(v8) - 128;
		r = 32'(row);
		c = 32'(col);
		w = 32'(cfg_width);
		h = 32'(cfg_height);
		if (cfg_mirror) begin
			c = w - 32'd1 - c;
		end
		// index arithmetic wraps at 32 bits like an unsigned int
		case (cfg_rot)
			ROT_0:   idx = c * h + (h - 32'd1 - r);
			ROT_90:  idx = r * w + c;
			ROT_180: idx = (w - 32'd1 - c) * h + r;
			default: idx = (h - 32'd1 - r) * w + (w - 32'd1 - c);
		endcase
		p.word  = {8'hFF,
			clamp_channel(128 * y + 227 * u),
			clamp_channel(128 * y - 44 * u - 91 * v),
			clamp_channel(128 * y + 179 * v)};
		p.index = idx[IDX_W-1:0];
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width  <= WIDTH_RESET;
			cfg_height <= HEIGHT_RESET;
			cfg_rot    <= ROT_0;
			cfg_mirror <= 1'b0;
			pending_pixels.delete();
			pending = 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (reg_idx_t'(paddr[ADDR_W-1:2]))
						REG_IMAGE_WIDTH:   cfg_width  <= saturate_dim(pwdata[DIM_W-1:0]);
						REG_IMAGE_HEIGHT:  cfg_height <= saturate_dim(pwdata[DIM_W-1:0]);
						REG_ROTATION_MODE: cfg_rot    <= rot_t'(pwdata[1:0]);
						default:           cfg_mirror <= pwdata[0];
					endcase
				end else begin
					case (reg_idx_t'(paddr[ADDR_W-1:2]))
						REG_IMAGE_WIDTH:   reg_value = DATA_W'(cfg_width);
						REG_IMAGE_HEIGHT:  reg_value = DATA_W'(cfg_height);
						REG_ROTATION_MODE: reg_value = DATA_W'(cfg_rot);
						default:           reg_value = DATA_W'(cfg_mirror);
					endcase
					if (prdata !== reg_value) begin
						report_mismatch("register read", prdata, reg_value);
					end
				end
			end
			// retire before queuing so a stray result never meets a fresh request
			if (result.valid && result.ready) begin
				if (pending_pixels.size() == 0) begin
					report_mismatch("result with no pixel pending", result.pixel_word, '0);
				end else begin
					want = pending_pixels.pop_front();
					if (result.pixel_word !== want.word) begin
						report_mismatch("pixel_word", result.pixel_word, want.word);
					end
					if (result.dest_index !== want.index) begin
						report_mismatch("dest_index", 32'(result.dest_index), 32'(want.index));
					end
				end
			end
			if (pixel.valid && pixel.ready) begin
				pending_pixels.push_back(convert_pixel(pixel.luma, pixel.chroma_blue,
					pixel.chroma_red, pixel.src_row, pixel.src_col));
			end
			pending = pending_pixels.size();
		end
	end

endmodule

// ===== tb/sv/yuv420_to_argb_rotate_fixed7_tb.sv =====
module yuv420_to_argb_rotate_fixed7_tb import yra_pkg::*; ();

	// items per configuration phase, corners included
	localparam int PHASE_ITEMS = 125;
	localparam int PHASES      = 8;
	// cycles the receiver holds off during the pressure phase
	localparam int HOLD_CYCLES = 200;

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	int                fail_count;
	int                pending;
	// calm: no idling on either side; squeeze: ask the receiver for one long hold-off
	bit                calm    = 1'b0;
	bit                squeeze = 1'b0;
	// effective image size, used only to aim positions inside the image
	int                cur_w   = 640;
	int                cur_h   = 480;

	yra_pixel_if  pixel ();
	yra_result_if result ();

	yuv420_to_argb_rotate_fixed7 uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixel   (pixel),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	yra_pixel_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel      (pixel),
		.result     (result),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.mismatches (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	// hard stop in case a handshake never completes
	initial begin
		#1_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// one bus transfer: setup phase, access phase, then back to idle so the
	// next transfer never lowers and raises psel in the same step
	task automatic apb_access(input bit is_write, input reg_idx_t idx,
		input logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// read back every register, the checker compares against its own copy
	task automatic read_all_registers();
		apb_access(1'b0, REG_IMAGE_WIDTH, '0);
		apb_access(1'b0, REG_IMAGE_HEIGHT, '0);
		apb_access(1'b0, REG_ROTATION_MODE, '0);
		apb_access(1'b0, REG_FRONT_FACING, '0);
	endtask

	// offer one pixel request, with random idle cycles in front of it
	task automatic send_pixel(input logic [SAMP_W-1:0] y, input logic [SAMP_W-1:0] u,
		input logic [SAMP_W-1:0] v, input logic [POS_W-1:0] row,
		input logic [POS_W-1:0] col);
		while (!calm && $urandom_range(99) < 27) begin
			pixel.valid <= 1'b0;
			@(posedge clk);
		end
		pixel.valid       <= 1'b1;
		pixel.luma        <= y;
		pixel.chroma_blue <= u;
		pixel.chroma_red  <= v;
		pixel.src_row     <= row;
		pixel.src_col     <= col;
		do @(posedge clk); while (!pixel.ready);
	endtask

	// stop offering and wait until every result has come back
	task automatic wait_drained();
		pixel.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	// samples lean on the clamp corners now and then
	function automatic logic [SAMP_W-1:0] random_sample();
		case ($urandom_range(7))
			0:       return 8'd0;
			1:       return 8'd255;
			2:       return 8'd128;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// mostly inside the image, sometimes anywhere in the 12-bit range so the
	// index arithmetic wraps
	function automatic logic [POS_W-1:0] random_pos(input int limit);
		if ($urandom_range(99) < 12) begin
			return 12'($urandom_range(4095));
		end
		return 12'($urandom_range(limit - 1));
	endfunction

	// receiver side: random stalls, one long hold-off when squeeze is raised
	initial begin
		int hold;
		bit held_once;
		hold      = 0;
		held_once = 1'b0;
		result.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (squeeze && !held_once) begin
				hold      = HOLD_CYCLES;
				held_once = 1'b1;
			end
			if (hold > 0) begin
				hold--;
				result.ready <= 1'b0;
			end else begin
				result.ready <= calm || ($urandom_range(99) >= 27);
			end
		end
	end

	initial begin
		int   raw_w;
		int   raw_h;
		rot_t rot;
		bit   mir;

		pixel.valid       <= 1'b0;
		pixel.luma        <= '0;
		pixel.chroma_blue <= '0;
		pixel.chroma_red  <= '0;
		pixel.src_row     <= '0;
		pixel.src_col     <= '0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values of all registers
		read_all_registers();

		// directed pixels at the reset setting, 640x480, no rotation, no mirror
		send_pixel(8'd0,   8'd0,   8'd0,   12'd0,    12'd0);    // red and blue below zero
		send_pixel(8'd255, 8'd255, 8'd255, 12'd479,  12'd639);  // last pixel, red and blue over
		send_pixel(8'd255, 8'd0,   8'd0,   12'd0,    12'd639);  // green over the top
		send_pixel(8'd0,   8'd255, 8'd255, 12'd479,  12'd0);    // green below zero
		send_pixel(8'd128, 8'd128, 8'd128, 12'd240,  12'd320);  // neutral grey
		send_pixel(8'd255, 8'd128, 8'd128, 12'd1,    12'd1);    // white, chroma neutral
		send_pixel(8'd0,   8'd128, 8'd255, 12'd100,  12'd200);  // red only
		send_pixel(8'd0,   8'd255, 8'd128, 12'd100,  12'd201);  // blue only
		send_pixel(8'd255, 8'd128, 8'd0,   12'd101,  12'd200);  // red pulled under
		send_pixel(8'd255, 8'd0,   8'd128, 12'd101,  12'd201);  // blue pulled under
		send_pixel(8'd1,   8'd127, 8'd129, 12'd2,    12'd3);    // just off neutral
		send_pixel(8'd254, 8'd129, 8'd127, 12'd3,    12'd2);
		send_pixel(8'd170, 8'd85,  8'd170, 12'd480,  12'd640);  // one past the image edge
		send_pixel(8'd85,  8'd170, 8'd85,  12'd4095, 12'd4095); // position far outside
		send_pixel(8'd16,  8'd240, 8'd16,  12'd2730, 12'd1365); // alternating bit patterns
		send_pixel(8'd235, 8'd16,  8'd240, 12'd1365, 12'd2730);
		wait_drained();

		for (int ph = 0; ph < PHASES; ph++) begin
			// extremes first, then random sizes that walk every rotation
			case (ph)
				0: begin
					raw_w = 1;    raw_h = 1;    cur_w = 1;    cur_h = 1;
					rot = ROT_90;  mir = 1'b1;
				end
				1: begin
					// too wide saturates down, zero height saturates up
					raw_w = 8191; raw_h = 0;    cur_w = 4096; cur_h = 1;
					rot = ROT_180; mir = 1'b0;
				end
				2: begin
					raw_w = 4096; raw_h = 4096; cur_w = 4096; cur_h = 4096;
					rot = ROT_270; mir = 1'b1;
				end
				3: begin
					raw_w = 4097; raw_h = 5000; cur_w = 4096; cur_h = 4096;
					rot = ROT_0;   mir = 1'b1;
				end
				default: begin
					raw_w = $urandom_range(1, 4096);
					raw_h = $urandom_range(1, 4096);
					cur_w = raw_w;
					cur_h = raw_h;
					rot   = rot_t'(ph - 4);
					mir   = (ph == 6);
				end
			endcase

			// junk in the upper data bits must be ignored
			apb_access(1'b1, REG_IMAGE_WIDTH,   {19'($urandom()), 13'(raw_w)});
			apb_access(1'b1, REG_IMAGE_HEIGHT,  {19'($urandom()), 13'(raw_h)});
			apb_access(1'b1, REG_ROTATION_MODE, {30'($urandom()), 2'(rot)});
			apb_access(1'b1, REG_FRONT_FACING,  {31'($urandom()), mir});
			read_all_registers();

			// one phase runs without idling, one carries the long receiver hold-off
			calm    <= (ph == 2);
			squeeze <= (ph == 5);

			// four image corners, then random pixels
			send_pixel(random_sample(), random_sample(), random_sample(),
				12'd0, 12'd0);
			send_pixel(random_sample(), random_sample(), random_sample(),
				12'd0, 12'(cur_w - 1));
			send_pixel(random_sample(), random_sample(), random_sample(),
				12'(cur_h - 1), 12'd0);
			send_pixel(random_sample(), random_sample(), random_sample(),
				12'(cur_h - 1), 12'(cur_w - 1));
			for (int i = 4; i < PHASE_ITEMS; i++) begin
				send_pixel(random_sample(), random_sample(), random_sample(),
					random_pos(cur_h), random_pos(cur_w));
			end
			wait_drained();
			calm    <= 1'b0;
			squeeze <= 1'b0;
		end

		// let the two pipeline stages settle before the verdict
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
